### hdl/imu_tilt_shake_gesture_detector_core_defines.svh
// Assertion macros shared by the gesture detector RTL
`ifndef IMU_TILT_SHAKE_GESTURE_DETECTOR_CORE_DEFINES_SVH
`define IMU_TILT_SHAKE_GESTURE_DETECTOR_CORE_DEFINES_SVH

`ifndef SYNTH
`define ITSG_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ITSG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ITSG_ASSERT(lbl, clk, rstn, prop, msg)
`define ITSG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### hdl/itsg_pkg.sv
// Types, widths and constants shared by the gesture detector
`default_nettype none

package itsg_pkg;

    localparam int ANGLE_W     = 16;
    localparam int ACCEL_W     = 16;
    localparam int RATE_W      = 16;
    localparam int TIME_W      = 32;
    localparam int REL_W       = 17;
    localparam int GEST_W      = 2;
    localparam int REFV_W      = 32;
    localparam int REF_FRAC    = 16;
    localparam int ONE_G       = 8192;
    localparam int EMA_WEIGHT  = 721;
    localparam int EMA_W       = 10;
    localparam int DIFF_W      = REFV_W + 1;
    localparam int PROD_W      = DIFF_W + EMA_W;
    localparam int SQ_W        = 31;
    localparam int SUM_W       = 32;
    localparam int BND_W       = 34;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int QPTR_W      = 2;
    localparam int QDEPTH      = 1 << QPTR_W;
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_TILT_THRESHOLD       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SHAKE_THRESHOLD      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_TIME        = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_STILL_RATE_LIMIT     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_STILL_NORM_TOLERANCE = CFG_IDX_W'(4);

    typedef enum logic [GEST_W-1:0] {
        GEST_NONE  = 2'd0,
        GEST_LEFT  = 2'd1,
        GEST_RIGHT = 2'd2,
        GEST_SHAKE = 2'd3
    } gesture_t;

    typedef struct packed {
        logic [14:0] tilt_threshold;
        logic [15:0] shake_threshold;
        logic [15:0] cooldown_time;
        logic [14:0] still_rate_limit;
        logic [12:0] still_norm_tolerance;
    } cfg_regs_t;

    localparam cfg_regs_t CFG_RESET = '{
        tilt_threshold:       15'd1280,
        shake_threshold:      16'd4096,
        cooldown_time:        16'd300,
        still_rate_limit:     15'd160,
        still_norm_tolerance: 13'd410
    };

    typedef struct packed {
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] roll;
        logic [TIME_W-1:0]         now;
        logic                      still;
        logic                      shake;
    } q_entry_t;

endpackage

`default_nettype wire

### hdl/itsg_ifs.sv
// Sample, result and configuration channel interfaces
`default_nettype none

interface itsg_in_if;
    import itsg_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
    logic signed [RATE_W-1:0]  rate_x;
    logic signed [RATE_W-1:0]  rate_y;
    logic [TIME_W-1:0]         now_ms;

    modport source (
        output valid, pitch_angle, roll_angle, accel_x, accel_y, accel_z,
        output rate_x, rate_y, now_ms,
        input  ready
    );
    modport sink (
        input  valid, pitch_angle, roll_angle, accel_x, accel_y, accel_z,
        input  rate_x, rate_y, now_ms,
        output ready
    );
endinterface

interface itsg_out_if;
    import itsg_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [GEST_W-1:0]       gesture;
    logic signed [REL_W-1:0] relative_pitch;
    logic signed [REL_W-1:0] relative_roll;

    modport source (output valid, gesture, relative_pitch, relative_roll, input ready);
    modport sink (input valid, gesture, relative_pitch, relative_roll, output ready);
endinterface

interface itsg_cfg_if;
    import itsg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

### hdl/imu_tilt_shake_gesture_detector_core.sv
// Top level of the IMU tilt and shake gesture detector
//
// channel   direction  handshake     payload
// samples   in         valid/ready   pitch, roll, accel x/y/z, rate x/y, now_ms
// results   out        valid/ready   gesture, relative_pitch, relative_roll
// cfg       in         valid/ready   index, wdata (ready held high)
//
// One request per cycle unless results stall; the back end reference update loop sets it.
// An accepted request passes front stages s1 and s2, the queue, back stage b1 and the output register.
// Reset clears pipeline valid flags, the four-entry queue, references and gesture history,
// and returns the configuration registers to their defaults.
// A stalled results channel fills the output register, back stage, queue and front stages
// in turn before samples.ready drops.
`default_nettype none

module imu_tilt_shake_gesture_detector_core (
    input  logic       clk,
    input  logic       rst_n,
    itsg_in_if.sink    samples,
    itsg_out_if.source results,
    itsg_cfg_if.sink   cfg
);
    import itsg_pkg::*;

    cfg_regs_t cfg_reg;
    logic      push_valid;
    logic      push_ready;
    q_entry_t  push_data;
    logic      pop_valid;
    logic      pop_ready;
    q_entry_t  pop_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_TILT_THRESHOLD:       cfg_reg.tilt_threshold       <= cfg.wdata[14:0];
                REG_SHAKE_THRESHOLD:      cfg_reg.shake_threshold      <= cfg.wdata;
                REG_COOLDOWN_TIME:        cfg_reg.cooldown_time        <= cfg.wdata;
                REG_STILL_RATE_LIMIT:     cfg_reg.still_rate_limit     <= cfg.wdata[14:0];
                REG_STILL_NORM_TOLERANCE: cfg_reg.still_norm_tolerance <= cfg.wdata[12:0];
                default:                  cfg_reg                      <= cfg_reg;
            endcase
        end
    end

    itsg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_regs   (cfg_reg),
        .samples    (samples),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    itsg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    itsg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_regs  (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .results   (results)
    );

endmodule

`default_nettype wire

### hdl/itsg_front.sv
// Front end: accept samples, form the squared norm and classify stillness and shake
`default_nettype none

module itsg_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  itsg_pkg::cfg_regs_t  cfg_regs,
    itsg_in_if.sink              samples,
    output logic                 push_valid,
    input  logic                 push_ready,
    output itsg_pkg::q_entry_t   push_data
);
    import itsg_pkg::*;

    typedef struct packed {
        logic [BND_W-1:0] still_lo_sq;
        logic [BND_W-1:0] still_hi_sq;
        logic [BND_W-1:0] shake_hi_sq;
        logic [BND_W-1:0] shake_lo_sq;
        logic             shake_lo_en;
    } bounds_t;

    logic                      s1_valid_reg;
    logic                      s2_valid_reg;
    logic                      s1_ready;
    logic                      s2_ready;
    logic                      take;

    logic [SQ_W-1:0]           s1_sqx_reg;
    logic [SQ_W-1:0]           s1_sqy_reg;
    logic [SQ_W-1:0]           s1_sqz_reg;
    logic signed [ANGLE_W-1:0] s1_pitch_reg;
    logic signed [ANGLE_W-1:0] s1_roll_reg;
    logic [TIME_W-1:0]         s1_now_reg;
    logic                      s1_rate_ok_reg;

    logic [SUM_W-1:0]          s2_sum_reg;
    logic signed [ANGLE_W-1:0] s2_pitch_reg;
    logic signed [ANGLE_W-1:0] s2_roll_reg;
    logic [TIME_W-1:0]         s2_now_reg;
    logic                      s2_rate_ok_reg;

    bounds_t                   bnd_reg;
    bounds_t                   bnd_next;

    logic signed [2*ACCEL_W-1:0] sqx;
    logic signed [2*ACCEL_W-1:0] sqy;
    logic signed [2*ACCEL_W-1:0] sqz;
    logic [RATE_W-1:0]           mag_x;
    logic [RATE_W-1:0]           mag_y;
    logic                        rate_ok;

    logic [13:0]       still_lo;
    logic [13:0]       still_hi;
    logic [16:0]       shake_hi;
    logic [13:0]       shake_lo;
    logic [27:0]       still_lo_sq;
    logic [27:0]       still_hi_sq;
    logic [33:0]       shake_hi_sq;
    logic [27:0]       shake_lo_sq;
    logic [BND_W-1:0]  sum_ext;

    assign s2_ready      = !s2_valid_reg || push_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign samples.ready = s1_ready;
    assign take          = samples.valid && s1_ready;

    assign sqx   = samples.accel_x * samples.accel_x;
    assign sqy   = samples.accel_y * samples.accel_y;
    assign sqz   = samples.accel_z * samples.accel_z;
    assign mag_x = samples.rate_x[RATE_W-1] ? (~samples.rate_x + 1'b1) : samples.rate_x;
    assign mag_y = samples.rate_y[RATE_W-1] ? (~samples.rate_y + 1'b1) : samples.rate_y;
    assign rate_ok = (mag_x < {1'b0, cfg_regs.still_rate_limit}) &&
                     (mag_y < {1'b0, cfg_regs.still_rate_limit});

    always_comb
    begin
        still_lo    = 14'(ONE_G) - {1'b0, cfg_regs.still_norm_tolerance};
        still_hi    = 14'(ONE_G) + {1'b0, cfg_regs.still_norm_tolerance};
        shake_hi    = 17'(ONE_G) + {1'b0, cfg_regs.shake_threshold};
        shake_lo    = 14'(ONE_G) - cfg_regs.shake_threshold[13:0];
        still_lo_sq = still_lo * still_lo;
        still_hi_sq = still_hi * still_hi;
        shake_hi_sq = shake_hi * shake_hi;
        shake_lo_sq = shake_lo * shake_lo;
        bnd_next.still_lo_sq = BND_W'(still_lo_sq);
        bnd_next.still_hi_sq = BND_W'(still_hi_sq);
        bnd_next.shake_hi_sq = shake_hi_sq;
        bnd_next.shake_lo_sq = BND_W'(shake_lo_sq);
        bnd_next.shake_lo_en = cfg_regs.shake_threshold < 16'(ONE_G);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= samples.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bnd_reg <= bnd_next;
        if (take)
        begin
            s1_sqx_reg     <= sqx[SQ_W-1:0];
            s1_sqy_reg     <= sqy[SQ_W-1:0];
            s1_sqz_reg     <= sqz[SQ_W-1:0];
            s1_pitch_reg   <= samples.pitch_angle;
            s1_roll_reg    <= samples.roll_angle;
            s1_now_reg     <= samples.now_ms;
            s1_rate_ok_reg <= rate_ok;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_sum_reg     <= SUM_W'(s1_sqx_reg) + SUM_W'(s1_sqy_reg) + SUM_W'(s1_sqz_reg);
            s2_pitch_reg   <= s1_pitch_reg;
            s2_roll_reg    <= s1_roll_reg;
            s2_now_reg     <= s1_now_reg;
            s2_rate_ok_reg <= s1_rate_ok_reg;
        end
    end

    assign sum_ext = BND_W'(s2_sum_reg);

    always_comb
    begin
        push_data.pitch = s2_pitch_reg;
        push_data.roll  = s2_roll_reg;
        push_data.now   = s2_now_reg;
        push_data.still = s2_rate_ok_reg &&
                          (sum_ext > bnd_reg.still_lo_sq) &&
                          (sum_ext < bnd_reg.still_hi_sq);
        push_data.shake = (sum_ext > bnd_reg.shake_hi_sq) ||
                          (bnd_reg.shake_lo_en && (sum_ext < bnd_reg.shake_lo_sq));
    end

    assign push_valid = s2_valid_reg;

endmodule

`default_nettype wire

### hdl/itsg_queue.sv
// Short request queue between the front end and the back end
`default_nettype none

`include "imu_tilt_shake_gesture_detector_core_defines.svh"

module itsg_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  itsg_pkg::q_entry_t  push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output itsg_pkg::q_entry_t  pop_data
);
    import itsg_pkg::*;

    q_entry_t            entries_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                push;
    logic                pop;

    assign push_ready = count_reg != QCNT_W'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ITSG_ASSERT(a_count_bound, clk, rst_n, count_reg <= QCNT_W'(QDEPTH), "queue count beyond depth")
    `ITSG_ASSERT(a_ptr_count, clk, rst_n, QPTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0], "queue pointers disagree with count")

endmodule

`default_nettype wire

### hdl/itsg_back.sv
// Back end: track references, form relative angles and decide the gesture
`default_nettype none

`include "imu_tilt_shake_gesture_detector_core_defines.svh"

module itsg_back (
    input  logic                clk,
    input  logic                rst_n,
    input  itsg_pkg::cfg_regs_t cfg_regs,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  itsg_pkg::q_entry_t  pop_data,
    itsg_out_if.source          results
);
    import itsg_pkg::*;

    localparam logic signed [PROD_W-1:0] EMA_MUL  = PROD_W'(EMA_WEIGHT);
    localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) <<< (REF_FRAC - 1);

    function automatic logic signed [REFV_W-1:0] ema_next(
        input logic signed [REFV_W-1:0]  cur,
        input logic signed [ANGLE_W-1:0] ang
    );
        logic signed [DIFF_W-1:0] diff;
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] step;
        diff = $signed({ang[ANGLE_W-1], ang, REF_FRAC'(0)}) - $signed({cur[REFV_W-1], cur});
        prod = diff * EMA_MUL;
        step = (prod + HALF_LSB) >>> REF_FRAC;
        return cur + step[REFV_W-1:0];
    endfunction

    function automatic logic signed [REL_W:0] rel_angle(
        input logic signed [REFV_W-1:0]  cur,
        input logic signed [ANGLE_W-1:0] ang
    );
        logic signed [REFV_W:0]  rsum;
        logic signed [REL_W-1:0] rnd;
        rsum = $signed({cur[REFV_W-1], cur}) + $signed((REFV_W + 1)'(1 << (REF_FRAC - 1)));
        rnd  = rsum[REFV_W:REF_FRAC];
        return $signed((REL_W + 1)'(ang)) - $signed({rnd[REL_W-1], rnd});
    endfunction

    logic                       b1_valid_reg;
    logic                       out_valid_reg;
    logic signed [REFV_W-1:0]   pitch_ref_reg;
    logic signed [REFV_W-1:0]   roll_ref_reg;
    gesture_t                   prev_gesture_reg;
    logic [TIME_W-1:0]          prev_time_reg;

    logic signed [ANGLE_W-1:0]  b1_pitch_reg;
    logic signed [ANGLE_W-1:0]  b1_roll_reg;
    logic [TIME_W-1:0]          b1_now_reg;
    logic                       b1_shake_reg;

    gesture_t                   gesture_reg;
    logic signed [REL_W-1:0]    pitch_delta_reg;
    logic signed [REL_W-1:0]    roll_delta_reg;

    logic                       out_ready;
    logic                       pop_fire;
    logic                       out_load;
    logic signed [REL_W:0]      pitch_delta;
    logic signed [REL_W:0]      roll_delta;
    logic signed [REL_W:0]      thr_pos;
    logic signed [REL_W:0]      thr_neg;
    logic [TIME_W-1:0]          elapsed;
    logic                       cooled;
    gesture_t                   detected;
    gesture_t                   gesture_next;
    gesture_t                   prev_gesture_next;
    logic [TIME_W-1:0]          prev_time_next;

    assign out_ready = !out_valid_reg || results.ready;
    assign pop_ready = !b1_valid_reg || out_ready;
    assign pop_fire  = pop_valid && pop_ready;
    assign out_load  = b1_valid_reg && out_ready;

    assign pitch_delta = rel_angle(pitch_ref_reg, b1_pitch_reg);
    assign roll_delta  = rel_angle(roll_ref_reg, b1_roll_reg);
    assign thr_pos   = $signed((REL_W + 1)'(cfg_regs.tilt_threshold));
    assign thr_neg   = -thr_pos;
    assign elapsed   = b1_now_reg - prev_time_reg;
    assign cooled    = elapsed > TIME_W'(cfg_regs.cooldown_time);

    always_comb
    begin
        if (pitch_delta > thr_pos)
        begin
            detected = GEST_RIGHT;
        end
        else if (pitch_delta < thr_neg)
        begin
            detected = GEST_LEFT;
        end
        else if (b1_shake_reg)
        begin
            detected = GEST_SHAKE;
        end
        else
        begin
            detected = GEST_NONE;
        end

        gesture_next      = GEST_NONE;
        prev_gesture_next = prev_gesture_reg;
        prev_time_next    = prev_time_reg;
        if (detected == GEST_NONE)
        begin
            prev_gesture_next = GEST_NONE;
        end
        else if ((detected != prev_gesture_reg) && cooled)
        begin
            gesture_next      = detected;
            prev_gesture_next = detected;
            prev_time_next    = b1_now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            pitch_ref_reg    <= '0;
            roll_ref_reg     <= '0;
            prev_gesture_reg <= GEST_NONE;
            prev_time_reg    <= '0;
        end
        else
        begin
            if (pop_ready)
            begin
                b1_valid_reg <= pop_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= b1_valid_reg;
            end
            if (pop_fire && pop_data.still)
            begin
                pitch_ref_reg <= ema_next(pitch_ref_reg, pop_data.pitch);
                roll_ref_reg  <= ema_next(roll_ref_reg, pop_data.roll);
            end
            if (out_load)
            begin
                prev_gesture_reg <= prev_gesture_next;
                prev_time_reg    <= prev_time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            b1_pitch_reg <= pop_data.pitch;
            b1_roll_reg  <= pop_data.roll;
            b1_now_reg   <= pop_data.now;
            b1_shake_reg <= pop_data.shake;
        end
        if (out_load)
        begin
            gesture_reg     <= gesture_next;
            pitch_delta_reg <= pitch_delta[REL_W-1:0];
            roll_delta_reg  <= roll_delta[REL_W-1:0];
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.gesture        = gesture_reg;
    assign results.relative_pitch = pitch_delta_reg;
    assign results.relative_roll  = roll_delta_reg;

    `ITSG_ASSERT_NEXT(a_prev_follows_emit, clk, rst_n, out_load, (gesture_reg == GEST_NONE) || (prev_gesture_reg == gesture_reg), "emitted gesture not recorded as previous")
    `ITSG_ASSERT_NEXT(a_ref_hold, clk, rst_n, !(pop_fire && pop_data.still), $stable(pitch_ref_reg) && $stable(roll_ref_reg), "reference moved without a still request")

endmodule

`default_nettype wire
